// File: rtl/core/polycen_pkg.sv
// Shared types and constants for the polygon centroid core.
`timescale 1ns / 1ps

package polycen_pkg;

    // Largest number of vertices that a polygon may have
    localparam int MAX_POINTS = 256;

    // Vertex count saturates at MAX_POINTS + 1
    localparam int CNT_W = $clog2(MAX_POINTS + 2);

    localparam int COORD_W = 16;
    localparam int AREA_W  = 42;
    localparam int WSUM_W  = 58;
    localparam int OUT_W   = 24;
    localparam int FRAC_W  = 8;

    // Multiplier operands: coordinate sum by cross product
    localparam int MUL_A_W = COORD_W + 1;
    localparam int CROSS_W = 2 * COORD_W + 1;
    localparam int MUL_P_W = MUL_A_W + CROSS_W;

    // Divider: divisor is 3 * |area|, quotient keeps 24 integer + 8 fraction bits
    localparam int DIV_W   = AREA_W + 2;
    localparam int QUO_W   = OUT_W + FRAC_W;
    localparam int ITER_W  = $clog2(QUO_W);

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_CENTROID = 3'd0,
        ST_SINGLE   = 3'd1,
        ST_MIDPOINT = 3'd2,
        ST_BOX      = 3'd3,
        ST_TOO_MANY = 3'd4,
        ST_SAT      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_M5,
        S_POST,
        S_AREA,
        S_DSET,
        S_DLOAD,
        S_DCHK,
        S_DIV,
        S_DRND,
        S_EMIT
    } state_t;

endpackage

// File: rtl/core/polygon_centroid_core.sv
// Polygon centroid core: shoelace accumulation with a shared multiplier and divider.
`timescale 1ns / 1ps

// Vertices come in one transfer at a time, in order, with last_point set on the final
// one. The core keeps the shoelace twice-area, the area-weighted coordinate sums and a
// bounding box, and on the last vertex closes the polygon back to the first vertex and
// returns one center in signed fixed point with 8 fraction bits plus a status code:
// the point itself for one vertex, the midpoint for two, sum / (3 * twice-area) rounded
// half away from zero for three or more, the box center when the area is zero, zeros
// with "too many points" beyond MAX_POINTS vertices, and clamped values with the
// saturated code when a coordinate leaves the 24-bit range. One signed 17 x 33
// multiplier is stepped by the sequencer through the four products of each edge, so a
// vertex with an edge holds point_stall through states S_M0 to S_M5 after its transfer;
// the first vertex of a polygon needs no edge. A last vertex of a polygon of three to
// MAX_POINTS vertices runs its own edge, the closing edge, and, for a nonzero area, a
// restoring divider that produces one quotient bit per cycle, 32 bits per coordinate.
// A finished result sits in the output register while the next polygon streams in;
// only a second result waits for the first to be taken.
module polygon_centroid_core
    import polycen_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    point_valid,
    output logic                    point_stall,
    input  logic signed [15:0]      point_x,
    input  logic signed [15:0]      point_y,
    input  logic                    last_point,

    output logic                    center_valid,
    input  logic                    center_stall,
    output logic [23:0]             center_x,
    output logic [23:0]             center_y,
    output logic [2:0]              status
);

    // Sequencer
    state_t state_reg, state_next;

    // Polygon state
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [COORD_W-1:0]  first_x_reg, first_x_next;
    logic signed [COORD_W-1:0]  first_y_reg, first_y_next;
    logic signed [COORD_W-1:0]  prev_x_reg, prev_x_next;
    logic signed [COORD_W-1:0]  prev_y_reg, prev_y_next;
    logic signed [COORD_W-1:0]  min_x_reg, min_x_next;
    logic signed [COORD_W-1:0]  max_x_reg, max_x_next;
    logic signed [COORD_W-1:0]  min_y_reg, min_y_next;
    logic signed [COORD_W-1:0]  max_y_reg, max_y_next;
    logic signed [AREA_W-1:0]   area_reg, area_next;
    logic signed [WSUM_W-1:0]   wsx_reg, wsx_next;
    logic signed [WSUM_W-1:0]   wsy_reg, wsy_next;
    logic                       last_reg, last_next;
    logic                       closing_reg, closing_next;

    // Edge operands and products
    logic signed [COORD_W-1:0]  ax_reg, ax_next;
    logic signed [COORD_W-1:0]  ay_reg, ay_next;
    logic signed [COORD_W-1:0]  bx_reg, bx_next;
    logic signed [COORD_W-1:0]  by_reg, by_next;
    logic signed [2*COORD_W-1:0] t0_reg, t0_next;
    logic signed [CROSS_W-1:0]  cross_reg, cross_next;
    logic signed [MUL_P_W-1:0]  prod_reg;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [CROSS_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  mul_p;

    // Divider
    logic                       aneg_reg, aneg_next;
    logic [AREA_W-1:0]          amag_reg, amag_next;
    logic [DIV_W-1:0]           d_reg, d_next;
    logic                       sel_reg, sel_next;
    logic                       sat_reg, sat_next;
    logic                       sneg_reg, sneg_next;
    logic [WSUM_W-1:0]          smag_reg, smag_next;
    logic [DIV_W-1:0]           rem_reg, rem_next;
    logic [QUO_W-1:0]           quo_reg, quo_next;
    logic [ITER_W-1:0]          iter_reg, iter_next;

    // Result staging and output register
    logic [OUT_W-1:0]           rx_reg, rx_next;
    logic [OUT_W-1:0]           ry_reg, ry_next;
    status_t                    rstat_reg, rstat_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]           out_x_reg, out_x_next;
    logic [OUT_W-1:0]           out_y_reg, out_y_next;
    status_t                    out_stat_reg, out_stat_next;

    // Combinational helpers
    logic                       edge_needed;
    logic signed [COORD_W:0]    sum_x, sum_y;
    logic [WSUM_W-1:0]          s_sel;
    logic                       coord_neg;
    logic                       over;
    logic [DIV_W:0]             trial;
    logic                       trial_ge;
    logic                       rnd_inc;
    logic [QUO_W:0]             mag;
    logic [OUT_W-1:0]           coord;
    logic                       coord_sat;

    assign mul_p = mul_a * mul_b;

    assign point_stall  = (state_reg != S_IDLE);
    assign center_valid = out_valid_reg;
    assign center_x     = out_x_reg;
    assign center_y     = out_y_reg;
    assign status       = out_stat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            min_x_reg     <= '0;
            max_x_reg     <= '0;
            min_y_reg     <= '0;
            max_y_reg     <= '0;
            area_reg      <= '0;
            wsx_reg       <= '0;
            wsy_reg       <= '0;
            last_reg      <= 1'b0;
            closing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            first_x_reg   <= first_x_next;
            first_y_reg   <= first_y_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            area_reg      <= area_next;
            wsx_reg       <= wsx_next;
            wsy_reg       <= wsy_next;
            last_reg      <= last_next;
            closing_reg   <= closing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        bx_reg       <= bx_next;
        by_reg       <= by_next;
        t0_reg       <= t0_next;
        cross_reg    <= cross_next;
        prod_reg     <= mul_p;
        aneg_reg     <= aneg_next;
        amag_reg     <= amag_next;
        d_reg        <= d_next;
        sel_reg      <= sel_next;
        sat_reg      <= sat_next;
        sneg_reg     <= sneg_next;
        smag_reg     <= smag_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        iter_reg     <= iter_next;
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        rstat_reg    <= rstat_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_stat_reg <= out_stat_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        area_next      = area_reg;
        wsx_next       = wsx_reg;
        wsy_next       = wsy_reg;
        last_next      = last_reg;
        closing_next   = closing_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        t0_next        = t0_reg;
        cross_next     = cross_reg;
        aneg_next      = aneg_reg;
        amag_next      = amag_reg;
        d_next         = d_reg;
        sel_next       = sel_reg;
        sat_next       = sat_reg;
        sneg_next      = sneg_reg;
        smag_next      = smag_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        iter_next      = iter_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rstat_next     = rstat_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_stat_next  = out_stat_reg;
        out_valid_next = out_valid_reg && center_stall;

        mul_a       = '0;
        mul_b       = '0;
        edge_needed = (cnt_reg != '0) && (cnt_reg < CNT_W'(MAX_POINTS));
        sum_x       = (COORD_W+1)'(ax_reg) + (COORD_W+1)'(bx_reg);
        sum_y       = (COORD_W+1)'(ay_reg) + (COORD_W+1)'(by_reg);
        s_sel       = sel_reg ? wsy_reg : wsx_reg;
        coord_neg   = sneg_reg ^ aneg_reg;
        over        = {{(DIV_W+QUO_W-WSUM_W-FRAC_W){1'b0}}, smag_reg, {FRAC_W{1'b0}}}
                      >= {d_reg, {QUO_W{1'b0}}};
        trial       = {rem_reg, quo_reg[QUO_W-1]};
        trial_ge    = trial >= {1'b0, d_reg};
        rnd_inc     = {rem_reg, 1'b0} >= {1'b0, d_reg};
        mag         = {1'b0, quo_reg} + {{QUO_W{1'b0}}, rnd_inc};
        coord       = '0;
        coord_sat   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (point_valid)
                begin
                    // edge operands take the previous vertex before it moves
                    ax_next      = prev_x_reg;
                    ay_next      = prev_y_reg;
                    bx_next      = point_x;
                    by_next      = point_y;
                    last_next    = last_point;
                    closing_next = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        first_x_next = point_x;
                        first_y_next = point_y;
                        min_x_next   = point_x;
                        max_x_next   = point_x;
                        min_y_next   = point_y;
                        max_y_next   = point_y;
                    end
                    else if (edge_needed)
                    begin
                        if (point_x < min_x_reg) min_x_next = point_x;
                        if (point_x > max_x_reg) max_x_next = point_x;
                        if (point_y < min_y_reg) min_y_next = point_y;
                        if (point_y > max_y_reg) max_y_next = point_y;
                    end
                    if (cnt_reg < CNT_W'(MAX_POINTS))
                    begin
                        prev_x_next = point_x;
                        prev_y_next = point_y;
                    end
                    if (cnt_reg <= CNT_W'(MAX_POINTS))
                        cnt_next = cnt_reg + 1'b1;
                    if (edge_needed)
                        state_next = S_M0;
                    else if (last_point)
                        state_next = S_POST;
                end
            end

            // cross = ax*by - ay*bx, then both weighted products
            S_M0:
            begin
                mul_a      = MUL_A_W'(ax_reg);
                mul_b      = CROSS_W'(by_reg);
                state_next = S_M1;
            end

            S_M1:
            begin
                mul_a      = MUL_A_W'(ay_reg);
                mul_b      = CROSS_W'(bx_reg);
                t0_next    = prod_reg[2*COORD_W-1:0];
                state_next = S_M2;
            end

            S_M2:
            begin
                cross_next = CROSS_W'(t0_reg) - CROSS_W'($signed(prod_reg[2*COORD_W-1:0]));
                state_next = S_M3;
            end

            S_M3:
            begin
                mul_a      = sum_x;
                mul_b      = cross_reg;
                area_next  = area_reg + AREA_W'(cross_reg);
                state_next = S_M4;
            end

            S_M4:
            begin
                mul_a      = sum_y;
                mul_b      = cross_reg;
                wsx_next   = wsx_reg + WSUM_W'(prod_reg);
                state_next = S_M5;
            end

            S_M5:
            begin
                wsy_next = wsy_reg + WSUM_W'(prod_reg);
                if (closing_reg)
                    state_next = S_AREA;
                else if (last_reg)
                    state_next = S_POST;
                else
                    state_next = S_IDLE;
            end

            S_POST:
            begin
                if (cnt_reg > CNT_W'(MAX_POINTS))
                begin
                    rx_next    = '0;
                    ry_next    = '0;
                    rstat_next = ST_TOO_MANY;
                    state_next = S_EMIT;
                end
                else if (cnt_reg == CNT_W'(1))
                begin
                    rx_next    = {first_x_reg, {FRAC_W{1'b0}}};
                    ry_next    = {first_y_reg, {FRAC_W{1'b0}}};
                    rstat_next = ST_SINGLE;
                    state_next = S_EMIT;
                end
                else if (cnt_reg == CNT_W'(2))
                begin
                    rx_next    = {(COORD_W+1)'(first_x_reg) + (COORD_W+1)'(prev_x_reg),
                                  {(FRAC_W-1){1'b0}}};
                    ry_next    = {(COORD_W+1)'(first_y_reg) + (COORD_W+1)'(prev_y_reg),
                                  {(FRAC_W-1){1'b0}}};
                    rstat_next = ST_MIDPOINT;
                    state_next = S_EMIT;
                end
                else
                begin
                    // closing edge: last vertex back to the first
                    ax_next      = prev_x_reg;
                    ay_next      = prev_y_reg;
                    bx_next      = first_x_reg;
                    by_next      = first_y_reg;
                    closing_next = 1'b1;
                    state_next   = S_M0;
                end
            end

            S_AREA:
            begin
                aneg_next = area_reg[AREA_W-1];
                amag_next = area_reg[AREA_W-1] ? (~area_reg + 1'b1) : area_reg;
                if (area_reg == '0)
                begin
                    rx_next    = {(COORD_W+1)'(min_x_reg) + (COORD_W+1)'(max_x_reg),
                                  {(FRAC_W-1){1'b0}}};
                    ry_next    = {(COORD_W+1)'(min_y_reg) + (COORD_W+1)'(max_y_reg),
                                  {(FRAC_W-1){1'b0}}};
                    rstat_next = ST_BOX;
                    state_next = S_EMIT;
                end
                else
                    state_next = S_DSET;
            end

            S_DSET:
            begin
                d_next     = {2'b00, amag_reg} + {1'b0, amag_reg, 1'b0};
                sel_next   = 1'b0;
                sat_next   = 1'b0;
                state_next = S_DLOAD;
            end

            S_DLOAD:
            begin
                sneg_next  = s_sel[WSUM_W-1];
                smag_next  = s_sel[WSUM_W-1] ? (~s_sel + 1'b1) : s_sel;
                state_next = S_DCHK;
            end

            S_DCHK:
            begin
                if (over)
                begin
                    // integer part alone already past 24 bits
                    coord     = coord_neg ? OUT_MIN : OUT_MAX;
                    coord_sat = 1'b1;
                    if (sel_reg)
                        ry_next = coord;
                    else
                        rx_next = coord;
                    sat_next = 1'b1;
                    if (sel_reg)
                    begin
                        rstat_next = ST_SAT;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sel_next   = 1'b1;
                        state_next = S_DLOAD;
                    end
                end
                else
                begin
                    rem_next   = DIV_W'(smag_reg[WSUM_W-1:QUO_W-FRAC_W]);
                    quo_next   = {smag_reg[QUO_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
                    iter_next  = ITER_W'(QUO_W - 1);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                // one restoring step: dividend bits shift out of quo as quotient bits enter
                if (trial_ge)
                    rem_next = DIV_W'(trial - {1'b0, d_reg});
                else
                    rem_next = trial[DIV_W-1:0];
                quo_next  = {quo_reg[QUO_W-2:0], trial_ge};
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                    state_next = S_DRND;
            end

            S_DRND:
            begin
                // half away from zero: magnitude rounds up when 2*rem >= d
                if (coord_neg)
                begin
                    if (mag > {{(QUO_W+1-OUT_W){1'b0}}, OUT_MIN})
                    begin
                        coord     = OUT_MIN;
                        coord_sat = 1'b1;
                    end
                    else
                        coord = ~mag[OUT_W-1:0] + 1'b1;
                end
                else
                begin
                    if (mag > {{(QUO_W+1-OUT_W){1'b0}}, OUT_MAX})
                    begin
                        coord     = OUT_MAX;
                        coord_sat = 1'b1;
                    end
                    else
                        coord = mag[OUT_W-1:0];
                end
                if (sel_reg)
                    ry_next = coord;
                else
                    rx_next = coord;
                sat_next = sat_reg | coord_sat;
                if (sel_reg)
                begin
                    rstat_next = (sat_reg | coord_sat) ? ST_SAT : ST_CENTROID;
                    state_next = S_EMIT;
                end
                else
                begin
                    sel_next   = 1'b1;
                    state_next = S_DLOAD;
                end
            end

            S_EMIT:
            begin
                // wait for the output register, then start a fresh polygon
                if (!out_valid_reg || !center_stall)
                begin
                    out_x_next     = rx_reg;
                    out_y_next     = ry_reg;
                    out_stat_next  = rstat_reg;
                    out_valid_next = 1'b1;
                    cnt_next       = '0;
                    area_next      = '0;
                    wsx_next       = '0;
                    wsy_next       = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Vertex count never runs past its saturation point
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_POINTS + 1))
        else $error("vertex count past saturation");

    // A non-final vertex never produces a result in the next cycle
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && !point_stall && !last_point |=> !$rose(center_valid))
        else $error("result raised by a non-final vertex");

    // Too many points reports a zero center
    a_too_many_zero: assert property (@(posedge clk) disable iff (!rst_n)
        center_valid && (status == ST_TOO_MANY) |-> (center_x == '0) && (center_y == '0))
        else $error("too-many-points result with nonzero center");

    // A saturated result has at least one coordinate at a range limit
    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        center_valid && (status == ST_SAT) |->
            (center_x == OUT_MAX) || (center_x == OUT_MIN) ||
            (center_y == OUT_MAX) || (center_y == OUT_MIN))
        else $error("saturated status without a clamped coordinate");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for polygon_centroid_core: vertex streams in, checked centers out.
`timescale 1ns / 1ps

module tb_top;
    import polycen_pkg::*;

    localparam int RANDOM_ITEMS = 1700;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int TAIL_CYCLES  = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        bit                 drain;  // wait for every result before offering this vertex
    } vertex_t;

    typedef struct {
        logic [23:0] cx;
        logic [23:0] cy;
        status_t     st;
    } center_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;

    logic               point_valid = 1'b0;
    logic               point_stall;
    logic signed [15:0] point_x = '0;
    logic signed [15:0] point_y = '0;
    logic               last_point = 1'b0;

    logic               center_valid;
    logic               center_stall = 1'b0;
    logic [23:0]        center_x;
    logic [23:0]        center_y;
    logic [2:0]         status;

    vertex_t pending_vertices[$];
    center_t expected_centers[$];

    // Counters shared between processes use nonblocking updates, all but mismatch_cnt.
    int unsigned cycle_cnt = 0;
    int unsigned predicted_cnt = 0;
    int unsigned checked_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned vertices_taken = 0;
    int unsigned polygons_queued = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned status_hits[8];

    // Sender pacing
    int unsigned burst_left;
    int unsigned gap_left;

    // Receiver pacing
    int unsigned hold_left;
    int unsigned holds_done;
    int unsigned stall_mode;
    int unsigned mode_left;

    // Shadow copy of the core's accumulator state
    int                 vtx_count = 0;
    logic signed [15:0] first_x = '0, first_y = '0;
    logic signed [15:0] prev_x = '0, prev_y = '0;
    logic signed [15:0] box_min_x = '0, box_max_x = '0;
    logic signed [15:0] box_min_y = '0, box_max_y = '0;
    logic [41:0]        area_sum = '0;
    logic [57:0]        wsum_x = '0, wsum_y = '0;

    polygon_centroid_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_stall  (point_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .last_point   (last_point),
        .center_valid (center_valid),
        .center_stall (center_stall),
        .center_x     (center_x),
        .center_y     (center_y),
        .status       (status)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // One polygon side a -> b: shoelace term and its weighted x/y terms, wrapping at
    // the accumulator widths.
    task automatic add_side(input longint ax, input longint ay,
                            input longint bx, input longint by);
        longint wedge;
        longint px;
        longint py;
        wedge = ax * by - ay * bx;
        px = (ax + bx) * wedge;
        py = (ay + by) * wedge;
        area_sum = area_sum + wedge[41:0];
        wsum_x   = wsum_x + px[57:0];
        wsum_y   = wsum_y + py[57:0];
    endtask

    // wsum * 256 / (3 * area), rounded half away from zero on magnitudes, clamped to 24 bits
    function automatic logic [23:0] scale_coord(input logic [57:0] wsum,
                                                input logic [41:0] area_mag,
                                                input bit area_neg,
                                                output bit clamped);
        logic [57:0]     s_mag;
        longint unsigned divisor;
        longint unsigned dividend;
        longint unsigned quo;
        longint unsigned rmd;
        longint unsigned frac;
        longint unsigned rest;
        longint unsigned mag;
        bit              neg;
        s_mag    = wsum[57] ? -wsum : wsum;
        neg      = wsum[57] ^ area_neg;
        divisor  = area_mag;
        divisor  = divisor * 3;
        dividend = s_mag;
        quo      = dividend / divisor;
        rmd      = dividend % divisor;
        clamped  = 1'b0;
        if (quo >= (64'd1 << 24)) begin
            clamped = 1'b1;
            return neg ? OUT_MIN : OUT_MAX;
        end
        frac = (rmd << 8) / divisor;
        rest = (rmd << 8) % divisor;
        if (rest * 2 >= divisor)
            frac++;
        mag = (quo << 8) + frac;
        if (neg) begin
            if (mag > 64'd8388608) begin
                clamped = 1'b1;
                return OUT_MIN;
            end
            mag = -mag;
            return mag[23:0];
        end
        if (mag > 64'd8388607) begin
            clamped = 1'b1;
            return OUT_MAX;
        end
        return mag[23:0];
    endfunction

    // Fold one accepted vertex into the shadow state; a last vertex yields one center.
    task automatic accumulate_vertex(input logic signed [15:0] x,
                                     input logic signed [15:0] y,
                                     input logic last);
        center_t     res;
        logic [41:0] a_mag;
        bit          a_neg;
        bit          clamp_x;
        bit          clamp_y;
        int          mid;
        if (vtx_count == 0) begin
            first_x = x;
            first_y = y;
            box_min_x = x;
            box_max_x = x;
            box_min_y = y;
            box_max_y = y;
        end else if (vtx_count < MAX_POINTS) begin
            add_side(prev_x, prev_y, x, y);
            if (x < box_min_x) box_min_x = x;
            if (x > box_max_x) box_max_x = x;
            if (y < box_min_y) box_min_y = y;
            if (y > box_max_y) box_max_y = y;
        end
        // Vertices past MAX_POINTS are counted but not folded in.
        if (vtx_count < MAX_POINTS) begin
            prev_x = x;
            prev_y = y;
        end
        if (vtx_count <= MAX_POINTS)
            vtx_count++;
        if (!last)
            return;

        if (vtx_count > MAX_POINTS) begin
            res.cx = '0;
            res.cy = '0;
            res.st = ST_TOO_MANY;
        end else if (vtx_count == 1) begin
            mid = int'(x) * 256;
            res.cx = mid[23:0];
            mid = int'(y) * 256;
            res.cy = mid[23:0];
            res.st = ST_SINGLE;
        end else if (vtx_count == 2) begin
            mid = (int'(first_x) + int'(x)) * 128;
            res.cx = mid[23:0];
            mid = (int'(first_y) + int'(y)) * 128;
            res.cy = mid[23:0];
            res.st = ST_MIDPOINT;
        end else begin
            // close the outline back to the first vertex
            add_side(x, y, first_x, first_y);
            a_neg = area_sum[41];
            a_mag = a_neg ? -area_sum : area_sum;
            if (a_mag == '0) begin
                mid = (int'(box_min_x) + int'(box_max_x)) * 128;
                res.cx = mid[23:0];
                mid = (int'(box_min_y) + int'(box_max_y)) * 128;
                res.cy = mid[23:0];
                res.st = ST_BOX;
            end else begin
                res.cx = scale_coord(wsum_x, a_mag, a_neg, clamp_x);
                res.cy = scale_coord(wsum_y, a_mag, a_neg, clamp_y);
                res.st = (clamp_x || clamp_y) ? ST_SAT : ST_CENTROID;
            end
        end
        expected_centers.push_back(res);

        vtx_count = 0;
        first_x = '0;
        first_y = '0;
        prev_x = '0;
        prev_y = '0;
        box_min_x = '0;
        box_max_x = '0;
        box_min_y = '0;
        box_max_y = '0;
        area_sum = '0;
        wsum_x = '0;
        wsum_y = '0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------

    task automatic queue_vertex(input int x, input int y, input bit last, input bit drain);
        vertex_t v;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        v.x = x[15:0];
        v.y = y[15:0];
        v.last = last;
        v.drain = drain;
        pending_vertices.push_back(v);
        if (last)
            polygons_queued++;
    endtask

    // style 0: anywhere in the plane; 1: cluster of random spread; 2: tight cluster
    // (degenerate areas, rounding ties); 3: points on a line (zero area)
    task automatic queue_polygon(input int n, input int style, input bit drain);
        int base_x;
        int base_y;
        int span;
        int dx;
        int dy;
        int x;
        int y;
        base_x = int'($urandom_range(0, 65535)) - 32768;
        base_y = int'($urandom_range(0, 65535)) - 32768;
        span = (style == 1) ? int'($urandom_range(1, 3000)) : int'($urandom_range(0, 4));
        dx = int'($urandom_range(0, 6)) - 3;
        dy = int'($urandom_range(0, 6)) - 3;
        for (int i = 0; i < n; i++) begin
            case (style)
                0: begin
                    x = int'($urandom_range(0, 65535)) - 32768;
                    y = int'($urandom_range(0, 65535)) - 32768;
                end
                1, 2: begin
                    x = base_x + int'($urandom_range(0, 2 * span)) - span;
                    y = base_y + int'($urandom_range(0, 2 * span)) - span;
                end
                default: begin
                    x = base_x + i * dx;
                    y = base_y + i * dy;
                end
            endcase
            queue_vertex(x, y, i == n - 1, drain && i == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of transfers with random gaps; the predictor runs on each transfer.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        vertex_t nxt;
        if (!rst_n) begin
            point_valid <= 1'b0;
            point_x <= '0;
            point_y <= '0;
            last_point <= 1'b0;
            burst_left <= 4;
            gap_left <= 0;
        end else begin
            if (point_valid && !point_stall) begin
                accumulate_vertex(point_x, point_y, last_point);
                vertices_taken <= vertices_taken + 1;
                if (last_point)
                    predicted_cnt <= predicted_cnt + 1;
            end
            // Payload may only change when nothing is on offer or the offer was taken.
            if (!point_valid || !point_stall) begin
                if (gap_left > 0) begin
                    point_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_vertices.size() == 0) begin
                    point_valid <= 1'b0;
                end else if (pending_vertices[0].drain &&
                             (point_valid || predicted_cnt != checked_cnt)) begin
                    // Pause until every center predicted so far has come out.
                    point_valid <= 1'b0;
                end else begin
                    nxt = pending_vertices.pop_front();
                    point_valid <= 1'b1;
                    point_x <= nxt.x;
                    point_y <= nxt.y;
                    last_point <= nxt.last;
                    if (burst_left <= 1) begin
                        burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                                 : $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left <= 0;
                            9:          gap_left <= $urandom_range(20, 60);
                            default:    gap_left <= $urandom_range(1, 8);
                        endcase
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall patterns that change every so often, plus two long hold-offs
    // that let the core back up and stall its vertex input.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            center_stall <= 1'b0;
            hold_left <= 0;
            holds_done <= 0;
            stall_mode <= 0;
            mode_left <= 50;
        end else if (hold_left > 0) begin
            center_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && results_seen >= (holds_done == 0 ? 12 : 150)) begin
            center_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left <= $urandom_range(20, 300);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       center_stall <= 1'b0;
                1:       center_stall <= ($urandom_range(0, 99) < 25);
                2:       center_stall <= ($urandom_range(0, 99) < 75);
                default: center_stall <= (cycle_cnt[2:0] < 3'd3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every center transfer is matched against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        center_t want;
        if (rst_n && center_valid && !center_stall) begin
            results_seen <= results_seen + 1;
            status_hits[status] <= status_hits[status] + 1;
            if (expected_centers.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("%0t: unexpected center x=%h y=%h status=%0d",
                             $realtime, center_x, center_y, status);
            end else begin
                want = expected_centers.pop_front();
                checked_cnt <= checked_cnt + 1;
                if (center_x !== want.cx || center_y !== want.cy || status !== want.st) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("%0t: center %0d mismatch: want x=%h y=%h st=%0d, got x=%h y=%h st=%0d",
                                 $realtime, checked_cnt, want.cx, want.cy, want.st,
                                 center_x, center_y, status);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d centers still outstanding",
                     cycle_cnt, expected_centers.size());
            $display("polygon_centroid_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int n;
        int style;
        int pick;
        int rand_polys;
        bit drain;

        // Directed polygons
        // single points at opposite corners of the coordinate range
        queue_vertex(-32768, 32767, 1'b1, 1'b0);
        queue_vertex(32767, -32768, 1'b1, 1'b0);
        // midpoint across the full diagonal
        queue_vertex(-32768, -32768, 1'b0, 1'b0);
        queue_vertex(32767, 32767, 1'b1, 1'b0);
        // unit right triangle: thirds exercise the rounding
        queue_vertex(0, 0, 1'b0, 1'b0);
        queue_vertex(1, 0, 1'b0, 1'b0);
        queue_vertex(0, 1, 1'b1, 1'b0);
        // clockwise winding, negative area and coordinates
        queue_vertex(-5, -5, 1'b0, 1'b0);
        queue_vertex(-5, 3, 1'b0, 1'b0);
        queue_vertex(7, -5, 1'b1, 1'b0);
        // collinear: zero area, box center fallback
        queue_vertex(0, 0, 1'b0, 1'b0);
        queue_vertex(5, 5, 1'b0, 1'b0);
        queue_vertex(10, 10, 1'b1, 1'b0);
        // symmetric bow tie: the two lobes cancel to zero area
        queue_vertex(-32768, -32768, 1'b0, 1'b0);
        queue_vertex(32767, 32767, 1'b0, 1'b0);
        queue_vertex(32767, -32768, 1'b0, 1'b0);
        queue_vertex(-32768, 32767, 1'b1, 1'b0);
        // nearly cancelling bow tie: tiny area, centroid far out of range, clamped
        queue_vertex(-32768, -32768, 1'b0, 1'b0);
        queue_vertex(32767, 32767, 1'b0, 1'b0);
        queue_vertex(32767, -32768, 1'b0, 1'b0);
        queue_vertex(-32768, 32766, 1'b1, 1'b0);
        // largest triangle
        queue_vertex(-32768, -32768, 1'b0, 1'b0);
        queue_vertex(32767, -32768, 1'b0, 1'b0);
        queue_vertex(-32768, 32767, 1'b1, 1'b0);

        // Random polygons, mostly short; one at exactly MAX_POINTS and one just past it.
        rand_polys = 0;
        while (pending_vertices.size() < RANDOM_ITEMS + 24) begin
            pick = $urandom_range(0, 99);
            if (rand_polys == 8)
                n = MAX_POINTS;
            else if (rand_polys == 20)
                n = MAX_POINTS + 1;
            else if (pick < 8)
                n = 1;
            else if (pick < 16)
                n = 2;
            else if (pick < 92)
                n = $urandom_range(3, 12);
            else
                n = $urandom_range(13, 60);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                style = 0;
            else if (pick < 70)
                style = 1;
            else if (pick < 85)
                style = 2;
            else
                style = 3;
            drain = (rand_polys == 5) || ($urandom_range(0, 24) == 0);
            queue_polygon(n, style, drain);
            rand_polys++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge, away from the driver's updates.
        do @(negedge clk); while (pending_vertices.size() != 0 || point_valid);
        do @(negedge clk); while (predicted_cnt != checked_cnt);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_centers.size() != 0)
            $display("%0d predicted centers never arrived", expected_centers.size());
        $display("Ran %0d polygons (%0d vertices) and checked %0d centers in %0d cycles",
                 polygons_queued, vertices_taken, checked_cnt, cycle_cnt);
        $display("Status mix: centroid %0d, single %0d, midpoint %0d, box %0d, too many %0d, clamped %0d",
                 status_hits[ST_CENTROID], status_hits[ST_SINGLE], status_hits[ST_MIDPOINT],
                 status_hits[ST_BOX], status_hits[ST_TOO_MANY], status_hits[ST_SAT]);
        if (mismatch_cnt == 0 && expected_centers.size() == 0)
            $display("polygon_centroid_core test passed");
        else
            $display("polygon_centroid_core test failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/polycen_pkg.sv
rtl/core/polygon_centroid_core.sv
tb/tb_top.sv
